/* src/pfrw_pkg.sv */
// Package for the phase-fair reader-writer lock manager.
// Holds sizing constants, codes and the structs shared by all modules but pfrw_ram.
// No dependencies.
package pfrw_pkg;

  localparam int unsigned WriterQueueDepth = 16;
  localparam int unsigned ReaderCountMax   = 255;

  localparam int unsigned QIdxW   = (WriterQueueDepth > 1) ? $clog2(WriterQueueDepth) : 1;
  localparam int unsigned QCntW   = $clog2(WriterQueueDepth + 1);
  localparam int unsigned RdrCntW = ($clog2(ReaderCountMax + 1) > 8) ?
                                    $clog2(ReaderCountMax + 1) : 8;

  localparam logic [QCntW-1:0]   QDepth    = QCntW'(WriterQueueDepth);
  localparam logic [RdrCntW-1:0] ReaderMax = RdrCntW'(ReaderCountMax);

  typedef enum logic [2:0] {
    OP_RLOCK = 3'd0,
    OP_TRYR  = 3'd1,
    OP_UNLR  = 3'd2,
    OP_WLOCK = 3'd3,
    OP_TRYW  = 3'd4,
    OP_UNLW  = 3'd5,
    OP_UNLX  = 3'd6,
    OP_NONE  = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_RGRANT    = 3'd0,
    ST_WGRANT    = 3'd1,
    ST_REFUSED   = 3'd2,
    ST_RWAIT     = 3'd3,
    ST_WQUEUED   = 3'd4,
    ST_UNLOCKED  = 3'd5,
    ST_FULL      = 3'd6,
    ST_BADUNLOCK = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    PH_FREE   = 2'd0,
    PH_WAITW  = 2'd1,
    PH_WRITER = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    CMD_RLOCK,
    CMD_TRYR,
    CMD_UNLR,
    CMD_WLOCK,
    CMD_TRYW,
    CMD_UNLW,
    CMD_UNLX,
    CMD_NOP
  } cmd_e;

  typedef struct packed {
    cmd_e       kind;
    logic [7:0] requester;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] requester_echo;
    logic       woken_writer_valid;
    logic [7:0] woken_writer;
    logic [7:0] readers_released;
    phase_e     phase_now;
    logic [7:0] readers_running_now;
  } res_t;

endpackage

/* src/pfrw_ram.sv */
// Generic simple dual-port RAM with registered read.
// One write port, one read port; no dependencies.
module pfrw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/pfrw_front.sv */
// Front stage: accepts requests, classifies the op code, and holds them
// in a two-entry command queue for the back stage. Uses pfrw_pkg.
module pfrw_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         op_i,
  input  logic [7:0]         requester_i,
  output pfrw_pkg::cmd_req_t cmd_req_o,
  input  logic               cmd_pop_i
);

  pfrw_pkg::cmd_t mem_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q;
  pfrw_pkg::cmd_t cmd_in;
  logic           do_push, do_pop;

  always_comb begin
    cmd_in.requester = requester_i;
    case (pfrw_pkg::op_e'(op_i))
      pfrw_pkg::OP_RLOCK: cmd_in.kind = pfrw_pkg::CMD_RLOCK;
      pfrw_pkg::OP_TRYR:  cmd_in.kind = pfrw_pkg::CMD_TRYR;
      pfrw_pkg::OP_UNLR:  cmd_in.kind = pfrw_pkg::CMD_UNLR;
      pfrw_pkg::OP_WLOCK: cmd_in.kind = pfrw_pkg::CMD_WLOCK;
      pfrw_pkg::OP_TRYW:  cmd_in.kind = pfrw_pkg::CMD_TRYW;
      pfrw_pkg::OP_UNLW:  cmd_in.kind = pfrw_pkg::CMD_UNLW;
      pfrw_pkg::OP_UNLX:  cmd_in.kind = pfrw_pkg::CMD_UNLX;
      default:            cmd_in.kind = pfrw_pkg::CMD_NOP;
    endcase
  end

  assign full    = (cnt_q == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = cmd_pop_i && (cnt_q != 2'd0);

  assign cmd_req_o.valid = (cnt_q != 2'd0);
  assign cmd_req_o.cmd   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_q <= ~wptr_q;
      end
      if (do_pop) begin
        rptr_q <= ~rptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* src/pfrw_back.sv */
// Back stage: executes lock commands against the phase, reader counters
// and the writer id queue (pfrw_ram). Uses pfrw_pkg.
module pfrw_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pfrw_pkg::cmd_req_t cmd_req_i,
  output logic               cmd_pop_o,
  output pfrw_pkg::res_t     res_o,
  output logic               res_push_o,
  input  logic               res_full_i
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e                        state_q, state_d;
  pfrw_pkg::cmd_t                cur_q, cur_d;
  pfrw_pkg::phase_e              phase_q, phase_d;
  logic [pfrw_pkg::RdrCntW-1:0]  running_q, running_d;
  logic [pfrw_pkg::RdrCntW-1:0]  waiting_q, waiting_d;
  logic [pfrw_pkg::QIdxW-1:0]    head_q, head_d;
  logic [pfrw_pkg::QCntW-1:0]    count_q, count_d;

  logic                          ram_we;
  logic [pfrw_pkg::QIdxW-1:0]    tail;
  logic [pfrw_pkg::QIdxW-1:0]    head_next;
  logic [pfrw_pkg::QCntW:0]      tail_sum;
  logic [7:0]                    ram_rdata;
  logic                          exec_go, do_unlr, do_unlw, grant;
  pfrw_pkg::status_e             st;
  logic [pfrw_pkg::RdrCntW-1:0]  released;

  pfrw_ram #(
    .Width(8),
    .Depth(pfrw_pkg::WriterQueueDepth)
  ) u_wq (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tail),
    .wdata_i(cur_q.requester),
    .raddr_i(head_q),
    .rdata_o(ram_rdata)
  );

  assign tail_sum = (pfrw_pkg::QCntW + 1)'(head_q) + (pfrw_pkg::QCntW + 1)'(count_q);
  assign tail = (tail_sum >= (pfrw_pkg::QCntW + 1)'(pfrw_pkg::WriterQueueDepth)) ?
                pfrw_pkg::QIdxW'(tail_sum - (pfrw_pkg::QCntW + 1)'(pfrw_pkg::WriterQueueDepth)) :
                pfrw_pkg::QIdxW'(tail_sum);
  assign head_next = (head_q == pfrw_pkg::QIdxW'(pfrw_pkg::WriterQueueDepth - 1)) ?
                     '0 : head_q + pfrw_pkg::QIdxW'(1);

  assign cmd_pop_o  = (state_q == S_IDLE) && cmd_req_i.valid;
  assign exec_go    = (state_q == S_EXEC) && !res_full_i;
  assign res_push_o = exec_go;

  assign do_unlr = (cur_q.kind == pfrw_pkg::CMD_UNLR) ||
                   ((cur_q.kind == pfrw_pkg::CMD_UNLX) && (phase_q != pfrw_pkg::PH_WRITER));
  assign do_unlw = (cur_q.kind == pfrw_pkg::CMD_UNLW) ||
                   ((cur_q.kind == pfrw_pkg::CMD_UNLX) && (phase_q == pfrw_pkg::PH_WRITER));

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    phase_d   = phase_q;
    running_d = running_q;
    waiting_d = waiting_q;
    head_d    = head_q;
    count_d   = count_q;
    ram_we    = 1'b0;
    grant     = 1'b0;
    released  = '0;
    st        = pfrw_pkg::ST_REFUSED;

    if (cmd_pop_o) begin
      cur_d   = cmd_req_i.cmd;
      state_d = S_EXEC;
    end

    if (exec_go) begin
      state_d = S_IDLE;
      case (cur_q.kind)
        pfrw_pkg::CMD_RLOCK: begin
          if (phase_q == pfrw_pkg::PH_FREE) begin
            if (running_q >= pfrw_pkg::ReaderMax) begin
              st = pfrw_pkg::ST_FULL;
            end else begin
              running_d = running_q + pfrw_pkg::RdrCntW'(1);
              st        = pfrw_pkg::ST_RGRANT;
            end
          end else if (waiting_q >= pfrw_pkg::ReaderMax) begin
            st = pfrw_pkg::ST_FULL;
          end else begin
            waiting_d = waiting_q + pfrw_pkg::RdrCntW'(1);
            st        = pfrw_pkg::ST_RWAIT;
          end
        end
        pfrw_pkg::CMD_TRYR: begin
          if (phase_q == pfrw_pkg::PH_FREE && running_q < pfrw_pkg::ReaderMax) begin
            running_d = running_q + pfrw_pkg::RdrCntW'(1);
            st        = pfrw_pkg::ST_RGRANT;
          end
        end
        pfrw_pkg::CMD_WLOCK: begin
          if (phase_q == pfrw_pkg::PH_FREE && running_q == '0) begin
            phase_d = pfrw_pkg::PH_WRITER;
            st      = pfrw_pkg::ST_WGRANT;
          end else if (count_q >= pfrw_pkg::QDepth) begin
            st = pfrw_pkg::ST_FULL;
          end else begin
            ram_we  = 1'b1;
            count_d = count_q + pfrw_pkg::QCntW'(1);
            if (phase_q == pfrw_pkg::PH_FREE) begin
              phase_d = pfrw_pkg::PH_WAITW;
            end
            st = pfrw_pkg::ST_WQUEUED;
          end
        end
        pfrw_pkg::CMD_TRYW: begin
          if (count_q == '0 && phase_q == pfrw_pkg::PH_FREE && running_q == '0) begin
            phase_d = pfrw_pkg::PH_WRITER;
            st      = pfrw_pkg::ST_WGRANT;
          end
        end
        default: begin
          st = pfrw_pkg::ST_REFUSED;
        end
      endcase

      if (do_unlr) begin
        if (phase_q == pfrw_pkg::PH_WRITER || running_q == '0) begin
          st = pfrw_pkg::ST_BADUNLOCK;
        end else begin
          st        = pfrw_pkg::ST_UNLOCKED;
          running_d = running_q - pfrw_pkg::RdrCntW'(1);
          if (running_q == pfrw_pkg::RdrCntW'(1) && phase_q == pfrw_pkg::PH_WAITW) begin
            if (count_q != '0) begin
              grant = 1'b1;
            end else begin
              phase_d = pfrw_pkg::PH_FREE;
            end
          end
        end
      end

      if (do_unlw) begin
        if (phase_q != pfrw_pkg::PH_WRITER) begin
          st = pfrw_pkg::ST_BADUNLOCK;
        end else begin
          st = pfrw_pkg::ST_UNLOCKED;
          if (waiting_q != '0) begin
            released  = waiting_q;
            running_d = waiting_q;
            waiting_d = '0;
            phase_d   = (count_q != '0) ? pfrw_pkg::PH_WAITW : pfrw_pkg::PH_FREE;
          end else if (count_q != '0) begin
            grant = 1'b1;
          end else begin
            phase_d = pfrw_pkg::PH_FREE;
          end
        end
      end

      if (grant) begin
        head_d  = head_next;
        count_d = count_q - pfrw_pkg::QCntW'(1);
        phase_d = pfrw_pkg::PH_WRITER;
      end
    end
  end

  assign res_o.status              = st;
  assign res_o.requester_echo      = cur_q.requester;
  assign res_o.woken_writer_valid  = grant;
  assign res_o.woken_writer        = grant ? ram_rdata : 8'd0;
  assign res_o.readers_released    = released[7:0];
  assign res_o.phase_now           = phase_d;
  assign res_o.readers_running_now = running_d[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cur_q     <= '{kind: pfrw_pkg::CMD_NOP, requester: 8'd0};
      phase_q   <= pfrw_pkg::PH_FREE;
      running_q <= '0;
      waiting_q <= '0;
      head_q    <= '0;
      count_q   <= '0;
    end else begin
      state_q   <= state_d;
      cur_q     <= cur_d;
      phase_q   <= phase_d;
      running_q <= running_d;
      waiting_q <= waiting_d;
      head_q    <= head_d;
      count_q   <= count_d;
    end
  end

  a_writer_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == pfrw_pkg::PH_WRITER |-> running_q == '0)
    else $error("writer active while readers run");

  a_free_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == pfrw_pkg::PH_FREE |-> (count_q == '0 && waiting_q == '0))
    else $error("free phase with waiters");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= pfrw_pkg::QDepth)
    else $error("writer queue count overflow");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |=> !res_push_o)
    else $error("two results for one command");

endmodule

/* src/pfrw_resq.sv */
// Result queue: two-entry buffer between the back stage and the result
// ports, so up to two results can wait before the back stage stalls. Uses pfrw_pkg.
module pfrw_resq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pfrw_pkg::res_t data_i,
  output logic           full_o,
  output logic           empty,
  input  logic           pop,
  output pfrw_pkg::res_t data_o
);

  pfrw_pkg::res_t mem_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty   = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop && !empty;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_q <= ~wptr_q;
      end
      if (do_pop) begin
        rptr_q <= ~rptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* src/phase_fair_rw_lock_manager.sv */
// Phase-fair reader-writer lock manager, top level.
// The back stage fetches and then executes each command, around the registered
// read of the writer id queue RAM, and takes no new command until the current
// one is executed and its result is accepted by the result queue.
// Reset clears phase, counters and both queues; the writer id RAM is not cleared.
module phase_fair_rw_lock_manager (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [2:0] op_i,
  input  logic [7:0] requester_i,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] status_o,
  output logic [7:0] requester_echo_o,
  output logic       woken_writer_valid_o,
  output logic [7:0] woken_writer_o,
  output logic [7:0] readers_released_o,
  output logic [1:0] phase_now_o,
  output logic [7:0] readers_running_now_o
);

  pfrw_pkg::cmd_req_t cmd_req;
  logic               cmd_pop;
  pfrw_pkg::res_t     res_in, res_out;
  logic               res_push, res_full;

  pfrw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .op_i       (op_i),
    .requester_i(requester_i),
    .cmd_req_o  (cmd_req),
    .cmd_pop_i  (cmd_pop)
  );

  pfrw_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_req_i (cmd_req),
    .cmd_pop_o (cmd_pop),
    .res_o     (res_in),
    .res_push_o(res_push),
    .res_full_i(res_full)
  );

  pfrw_resq u_resq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(res_push),
    .data_i(res_in),
    .full_o(res_full),
    .empty (empty),
    .pop   (pop),
    .data_o(res_out)
  );

  assign status_o              = 3'(res_out.status);
  assign requester_echo_o      = res_out.requester_echo;
  assign woken_writer_valid_o  = res_out.woken_writer_valid;
  assign woken_writer_o        = res_out.woken_writer;
  assign readers_released_o    = res_out.readers_released;
  assign phase_now_o           = 2'(res_out.phase_now);
  assign readers_running_now_o = res_out.readers_running_now;

endmodule

/* verif/phase_fair_rw_lock_manager_test.sv */
// Self-checking testbench for the phase-fair reader-writer lock manager.
// Drives a directed table, a counter saturation run and random request traffic.
// Each response is checked against a lock predictor. Depends on pfrw_pkg.
module phase_fair_rw_lock_manager_test;

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [2:0] op_i;
  logic [7:0] requester_i;
  logic       empty;
  logic       pop;
  logic [2:0] status_o;
  logic [7:0] requester_echo_o;
  logic       woken_writer_valid_o;
  logic [7:0] woken_writer_o;
  logic [7:0] readers_released_o;
  logic [1:0] phase_now_o;
  logic [7:0] readers_running_now_o;

  phase_fair_rw_lock_manager u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .push                 (push),
    .full                 (full),
    .op_i                 (op_i),
    .requester_i          (requester_i),
    .empty                (empty),
    .pop                  (pop),
    .status_o             (status_o),
    .requester_echo_o     (requester_echo_o),
    .woken_writer_valid_o (woken_writer_valid_o),
    .woken_writer_o       (woken_writer_o),
    .readers_released_o   (readers_released_o),
    .phase_now_o          (phase_now_o),
    .readers_running_now_o(readers_running_now_o)
  );

  typedef struct {
    pfrw_pkg::op_e     op;
    logic [7:0]        who;
    bit                typed;
    pfrw_pkg::status_e st;
  } lock_req_t;

  // Lock predictor state
  pfrw_pkg::phase_e lk_phase;
  int unsigned      rd_run;
  int unsigned      rd_wait;
  int unsigned      q_head;
  int unsigned      q_cnt;
  logic [7:0]       wr_ids [pfrw_pkg::WriterQueueDepth];
  pfrw_pkg::res_t   lk_resp;

  pfrw_pkg::res_t   lock_resp_q [$];
  int               mismatch_cnt;
  int               send_idle;
  int               rcv_idle;
  bit               hold_req;
  lock_req_t        directed_reqs [23];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(20 * 200000);
    $display("Regression FAIL");
    $finish;
  end

  task automatic flag_mismatch(input string fld, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatch_cnt < 100) begin
      $display("mismatch %s: got %0h expected %0h", fld, got, want);
    end
    mismatch_cnt++;
  endtask

  function automatic void grant_queued_writer();
    lk_resp.woken_writer_valid = 1'b1;
    lk_resp.woken_writer = wr_ids[pfrw_pkg::QIdxW'(q_head)];
    q_head = (q_head + 1) % pfrw_pkg::WriterQueueDepth;
    q_cnt--;
    lk_phase = pfrw_pkg::PH_WRITER;
  endfunction

  function automatic pfrw_pkg::status_e release_read();
    if (lk_phase == pfrw_pkg::PH_WRITER || rd_run == 0) begin
      return pfrw_pkg::ST_BADUNLOCK;
    end
    rd_run--;
    if (rd_run == 0 && lk_phase == pfrw_pkg::PH_WAITW) begin
      if (q_cnt > 0) begin
        grant_queued_writer();
      end else begin
        lk_phase = pfrw_pkg::PH_FREE;
      end
    end
    return pfrw_pkg::ST_UNLOCKED;
  endfunction

  function automatic pfrw_pkg::status_e release_write();
    if (lk_phase != pfrw_pkg::PH_WRITER) begin
      return pfrw_pkg::ST_BADUNLOCK;
    end
    if (rd_wait > 0) begin
      lk_resp.readers_released = rd_wait[7:0];
      rd_run = rd_wait;
      rd_wait = 0;
      lk_phase = (q_cnt > 0) ? pfrw_pkg::PH_WAITW : pfrw_pkg::PH_FREE;
    end else if (q_cnt > 0) begin
      grant_queued_writer();
    end else begin
      lk_phase = pfrw_pkg::PH_FREE;
    end
    return pfrw_pkg::ST_UNLOCKED;
  endfunction

  function automatic pfrw_pkg::res_t arbitrate(input pfrw_pkg::op_e op,
                                               input logic [7:0] req);
    lk_resp = '0;
    lk_resp.requester_echo = req;
    lk_resp.status = pfrw_pkg::ST_REFUSED;
    case (op)
      pfrw_pkg::OP_RLOCK: begin
        if (lk_phase == pfrw_pkg::PH_FREE) begin
          if (rd_run >= pfrw_pkg::ReaderCountMax) begin
            lk_resp.status = pfrw_pkg::ST_FULL;
          end else begin
            rd_run++;
            lk_resp.status = pfrw_pkg::ST_RGRANT;
          end
        end else if (rd_wait >= pfrw_pkg::ReaderCountMax) begin
          lk_resp.status = pfrw_pkg::ST_FULL;
        end else begin
          rd_wait++;
          lk_resp.status = pfrw_pkg::ST_RWAIT;
        end
      end
      pfrw_pkg::OP_TRYR: begin
        if (lk_phase == pfrw_pkg::PH_FREE && rd_run < pfrw_pkg::ReaderCountMax) begin
          rd_run++;
          lk_resp.status = pfrw_pkg::ST_RGRANT;
        end
      end
      pfrw_pkg::OP_UNLR: lk_resp.status = release_read();
      pfrw_pkg::OP_WLOCK: begin
        if (lk_phase == pfrw_pkg::PH_FREE && rd_run == 0) begin
          lk_phase = pfrw_pkg::PH_WRITER;
          lk_resp.status = pfrw_pkg::ST_WGRANT;
        end else if (q_cnt >= pfrw_pkg::WriterQueueDepth) begin
          lk_resp.status = pfrw_pkg::ST_FULL;
        end else begin
          wr_ids[pfrw_pkg::QIdxW'((q_head + q_cnt) % pfrw_pkg::WriterQueueDepth)] = req;
          q_cnt++;
          if (lk_phase == pfrw_pkg::PH_FREE) begin
            lk_phase = pfrw_pkg::PH_WAITW;
          end
          lk_resp.status = pfrw_pkg::ST_WQUEUED;
        end
      end
      pfrw_pkg::OP_TRYW: begin
        if (q_cnt == 0 && lk_phase == pfrw_pkg::PH_FREE && rd_run == 0) begin
          lk_phase = pfrw_pkg::PH_WRITER;
          lk_resp.status = pfrw_pkg::ST_WGRANT;
        end
      end
      pfrw_pkg::OP_UNLW: lk_resp.status = release_write();
      pfrw_pkg::OP_UNLX: begin
        lk_resp.status = (lk_phase == pfrw_pkg::PH_WRITER) ? release_write() :
                                                             release_read();
      end
      default: lk_resp.status = pfrw_pkg::ST_REFUSED;
    endcase
    lk_resp.phase_now = lk_phase;
    lk_resp.readers_running_now = rd_run[7:0];
    return lk_resp;
  endfunction

  function automatic pfrw_pkg::op_e pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r >= 85) begin
      return pfrw_pkg::op_e'(3'($urandom_range(0, 7)));
    end
    if (lk_phase == pfrw_pkg::PH_WRITER) begin
      if (r < 45) return pfrw_pkg::OP_UNLW;
      if (r < 55) return pfrw_pkg::OP_UNLX;
      if (r < 70) return pfrw_pkg::OP_RLOCK;
      return pfrw_pkg::OP_WLOCK;
    end
    if (rd_run > 0) begin
      if (r < 30) return pfrw_pkg::OP_UNLR;
      if (r < 40) return pfrw_pkg::OP_UNLX;
      if (r < 58) return pfrw_pkg::OP_RLOCK;
      if (r < 66) return pfrw_pkg::OP_TRYR;
      if (r < 78) return pfrw_pkg::OP_WLOCK;
      return pfrw_pkg::OP_TRYW;
    end
    if (r < 30) return pfrw_pkg::OP_RLOCK;
    if (r < 45) return pfrw_pkg::OP_TRYR;
    if (r < 65) return pfrw_pkg::OP_WLOCK;
    return pfrw_pkg::OP_TRYW;
  endfunction

  task automatic issue_request(input pfrw_pkg::op_e op, input logic [7:0] req,
                               input bit typed, input pfrw_pkg::status_e st);
    pfrw_pkg::res_t r;
    while ($urandom_range(0, 99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push        <= 1'b1;
    op_i        <= op;
    requester_i <= req;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    r = arbitrate(op, req);
    if (typed) begin
      r.status = st;
    end
    lock_resp_q.push_back(r);
  endtask

  task automatic run_random(input int n);
    repeat (n) issue_request(pick_op(), 8'($urandom_range(0, 255)), 1'b0,
                             pfrw_pkg::ST_REFUSED);
  endtask

  task automatic wait_drained();
    int n;
    n = 0;
    push <= 1'b0;
    while (lock_resp_q.size() != 0 && n < 5000) begin
      @(posedge clk_i);
      n++;
    end
    if (lock_resp_q.size() != 0) begin
      flag_mismatch("responses missing", 32'd0, 32'(lock_resp_q.size()));
      lock_resp_q.delete();
    end
  endtask

  task automatic saturate_counters();
    for (int i = 0; i < 255; i++) begin
      issue_request((i % 2) ? pfrw_pkg::OP_TRYR : pfrw_pkg::OP_RLOCK,
                    8'($urandom_range(0, 255)), 1'b0, pfrw_pkg::ST_REFUSED);
    end
    issue_request(pfrw_pkg::OP_RLOCK, 8'h11, 1'b1, pfrw_pkg::ST_FULL);
    issue_request(pfrw_pkg::OP_TRYR, 8'h22, 1'b1, pfrw_pkg::ST_REFUSED);
    repeat (pfrw_pkg::WriterQueueDepth) issue_request(pfrw_pkg::OP_WLOCK,
                                                      8'($urandom_range(0, 255)), 1'b0,
                                                      pfrw_pkg::ST_REFUSED);
    issue_request(pfrw_pkg::OP_WLOCK, 8'h33, 1'b1, pfrw_pkg::ST_FULL);
    repeat (255) issue_request(pfrw_pkg::OP_RLOCK, 8'($urandom_range(0, 255)), 1'b0,
                               pfrw_pkg::ST_REFUSED);
    issue_request(pfrw_pkg::OP_RLOCK, 8'h44, 1'b1, pfrw_pkg::ST_FULL);
    issue_request(pfrw_pkg::OP_TRYW, 8'h55, 1'b1, pfrw_pkg::ST_REFUSED);
    while (lk_phase != pfrw_pkg::PH_FREE || rd_run != 0) begin
      issue_request((lk_phase == pfrw_pkg::PH_WRITER) ? pfrw_pkg::OP_UNLW : pfrw_pkg::OP_UNLR,
                    8'($urandom_range(0, 255)), 1'b0, pfrw_pkg::ST_REFUSED);
    end
  endtask

  task automatic check_resp();
    pfrw_pkg::res_t w;
    if (lock_resp_q.size() == 0) begin
      flag_mismatch("unexpected response status", 32'(status_o), 32'd0);
      return;
    end
    w = lock_resp_q.pop_front();
    if (status_o !== w.status) flag_mismatch("status", 32'(status_o), 32'(w.status));
    if (requester_echo_o !== w.requester_echo) begin
      flag_mismatch("requester_echo", 32'(requester_echo_o), 32'(w.requester_echo));
    end
    if (woken_writer_valid_o !== w.woken_writer_valid) begin
      flag_mismatch("woken_writer_valid", 32'(woken_writer_valid_o),
                    32'(w.woken_writer_valid));
    end
    if (woken_writer_o !== w.woken_writer) begin
      flag_mismatch("woken_writer", 32'(woken_writer_o), 32'(w.woken_writer));
    end
    if (readers_released_o !== w.readers_released) begin
      flag_mismatch("readers_released", 32'(readers_released_o), 32'(w.readers_released));
    end
    if (phase_now_o !== w.phase_now) begin
      flag_mismatch("phase_now", 32'(phase_now_o), 32'(w.phase_now));
    end
    if (readers_running_now_o !== w.readers_running_now) begin
      flag_mismatch("readers_running_now", 32'(readers_running_now_o),
                    32'(w.readers_running_now));
    end
  endtask

  // Response side: check accepted transactions, then pick the next pop
  initial begin
    int hold_left;
    hold_left = 0;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        check_resp();
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 80;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= rcv_idle);
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    push         = 1'b0;
    op_i         = '0;
    requester_i  = '0;
    mismatch_cnt = 0;
    hold_req     = 1'b0;
    send_idle    = 25;
    rcv_idle     = 55;
    lk_phase     = pfrw_pkg::PH_FREE;
    rd_run       = 0;
    rd_wait      = 0;
    q_head       = 0;
    q_cnt        = 0;
    foreach (wr_ids[i]) wr_ids[i] = '0;
    directed_reqs = '{
      '{pfrw_pkg::OP_UNLR,  8'h00, 1'b1, pfrw_pkg::ST_BADUNLOCK},
      '{pfrw_pkg::OP_UNLW,  8'hFF, 1'b1, pfrw_pkg::ST_BADUNLOCK},
      '{pfrw_pkg::OP_UNLX,  8'h00, 1'b1, pfrw_pkg::ST_BADUNLOCK},
      '{pfrw_pkg::OP_NONE,  8'h7F, 1'b1, pfrw_pkg::ST_REFUSED},
      '{pfrw_pkg::OP_TRYW,  8'h5A, 1'b1, pfrw_pkg::ST_WGRANT},
      '{pfrw_pkg::OP_RLOCK, 8'h01, 1'b0, pfrw_pkg::ST_REFUSED},
      '{pfrw_pkg::OP_TRYR,  8'h02, 1'b1, pfrw_pkg::ST_REFUSED},
      '{pfrw_pkg::OP_WLOCK, 8'hA5, 1'b0, pfrw_pkg::ST_REFUSED},
      '{pfrw_pkg::OP_UNLR,  8'h80, 1'b1, pfrw_pkg::ST_BADUNLOCK},
      '{pfrw_pkg::OP_UNLW,  8'h5A, 1'b0, pfrw_pkg::ST_REFUSED},
      '{pfrw_pkg::OP_RLOCK, 8'h03, 1'b0, pfrw_pkg::ST_REFUSED},
      '{pfrw_pkg::OP_UNLX,  8'h01, 1'b0, pfrw_pkg::ST_REFUSED},
      '{pfrw_pkg::OP_WLOCK, 8'hFF, 1'b0, pfrw_pkg::ST_REFUSED},
      '{pfrw_pkg::OP_UNLX,  8'hA5, 1'b0, pfrw_pkg::ST_REFUSED},
      '{pfrw_pkg::OP_UNLR,  8'h03, 1'b0, pfrw_pkg::ST_REFUSED},
      '{pfrw_pkg::OP_UNLW,  8'hFF, 1'b0, pfrw_pkg::ST_REFUSED},
      '{pfrw_pkg::OP_TRYR,  8'h00, 1'b0, pfrw_pkg::ST_REFUSED},
      '{pfrw_pkg::OP_WLOCK, 8'h00, 1'b0, pfrw_pkg::ST_REFUSED},
      '{pfrw_pkg::OP_TRYW,  8'hC3, 1'b1, pfrw_pkg::ST_REFUSED},
      '{pfrw_pkg::OP_UNLR,  8'h00, 1'b0, pfrw_pkg::ST_REFUSED},
      '{pfrw_pkg::OP_UNLX,  8'h00, 1'b0, pfrw_pkg::ST_REFUSED},
      '{pfrw_pkg::OP_RLOCK, 8'hFF, 1'b0, pfrw_pkg::ST_REFUSED},
      '{pfrw_pkg::OP_UNLR,  8'hFF, 1'b0, pfrw_pkg::ST_REFUSED}
    };
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_reqs[i]) begin
      issue_request(directed_reqs[i].op, directed_reqs[i].who, directed_reqs[i].typed,
                    directed_reqs[i].st);
    end
    saturate_counters();
    run_random(300);

    send_idle = 55;
    rcv_idle  = 25;
    run_random(300);

    send_idle = 0;
    rcv_idle  = 0;
    hold_req  = 1'b1;
    run_random(60);
    wait_drained();
    run_random(300);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
src/pfrw_pkg.sv
src/pfrw_ram.sv
src/pfrw_front.sv
src/pfrw_back.sv
src/pfrw_resq.sv
src/phase_fair_rw_lock_manager.sv
verif/phase_fair_rw_lock_manager_test.sv
